@@ design/rclf_pkg.sv @@
// rclf_pkg: types, codes and reset constants for the radio-link failsafe monitor.
// Used by rc_link_failsafe_monitor; depends on nothing else.
`default_nettype none

package rclf_pkg;

	localparam int unsigned TimeW  = 32;
	localparam int unsigned CfgW   = 16;
	localparam int unsigned CountW = 32;
	localparam int unsigned FrameW = 16;
	localparam int unsigned CfgIdxW = 2;

	typedef enum logic [1:0] {
		PH_WAITING    = 2'd0,
		PH_RECOVERING = 2'd1,
		PH_HEALTHY    = 2'd2,
		PH_LOST       = 2'd3
	} phase_t;

	typedef enum logic {
		OP_FRAME = 1'b0,
		OP_CHECK = 1'b1
	} opcode_t;

	typedef enum logic [CfgIdxW-1:0] {
		REG_LOSS_TIMEOUT  = 2'd0,
		REG_RECOVERY_TIME = 2'd1,
		REG_RECOVERY_MIN  = 2'd2,
		REG_UNUSED        = 2'd3
	} cfg_reg_t;

	localparam logic [CfgW-1:0] LossTimeoutRst  = 16'd200;
	localparam logic [CfgW-1:0] RecoveryTimeRst = 16'd1000;
	localparam logic [CfgW-1:0] RecoveryMinRst  = 16'd10;
	localparam logic [FrameW-1:0] FrameMax      = {FrameW{1'b1}};

	typedef struct packed {
		logic             opcode;
		logic [TimeW-1:0] now_ms;
	} in_item_t;

	typedef struct packed {
		logic [1:0]        link_phase;
		logic              failsafe_on;
		logic              control_ok;
		logic [CountW-1:0] failsafe_events;
		logic [CountW-1:0] recovery_events;
		logic [TimeW-1:0]  last_failsafe_time;
		logic [FrameW-1:0] recovery_frames;
	} out_item_t;

endpackage

`default_nettype wire

@@ design/rc_link_failsafe_monitor.sv @@
// rc_link_failsafe_monitor: link loss / recovery tracker for a radio receiver.
// Depends on rclf_pkg for types, codes and reset constants.
//
// Usage:
//   in channel  (in_valid / in_stall / in_data): one request per frame event
//     (opcode frame) or periodic check (opcode check), each with a ms timestamp.
//   out channel (out_valid / out_stall / out_data): exactly one result per
//     request: phase, failsafe and control-valid flags, event counters.
//   cfg channel (cfg_valid / cfg_ready / cfg_index / cfg_data): register writes,
//     always ready; index 0 loss timeout, 1 recovery time, 2 minimum frames,
//     other indexes are dropped. Write only while no result is pending.
// Timing: the link state is updated at the accepting edge and the result is
//   held in a single output register, valid in the cycle after acceptance;
//   one request is taken every cycle unless stalled; the limit is that register.
// Stall: while a result waits with out_stall high, in_stall is raised; as soon
//   as the result is taken, a new request is accepted in the same cycle.
// Reset: arst_n clears the link to waiting with failsafe active, counters to
//   zero, registers to 200 ms / 1000 ms / 10 frames, and the output empty.
`default_nettype none

module rc_link_failsafe_monitor (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              in_valid,
	output logic                                   in_stall,
	input  wire rclf_pkg::in_item_t                in_data,
	output logic                                   out_valid,
	input  wire logic                              out_stall,
	output rclf_pkg::out_item_t                    out_data,
	input  wire logic                              cfg_valid,
	output logic                                   cfg_ready,
	input  wire logic [rclf_pkg::CfgIdxW-1:0]      cfg_index,
	input  wire logic [rclf_pkg::CfgW-1:0]         cfg_data
);

	logic [rclf_pkg::CfgW-1:0]   loss_timeout_q, recovery_time_q, recovery_min_q;

	rclf_pkg::phase_t            phase_q, phase_d;
	logic                        seen_q, seen_d;
	logic                        failsafe_q, failsafe_d;
	logic [rclf_pkg::TimeW-1:0]  last_frame_q, last_frame_d;
	logic [rclf_pkg::TimeW-1:0]  rec_start_q, rec_start_d;
	logic [rclf_pkg::TimeW-1:0]  last_loss_q, last_loss_d;
	logic [rclf_pkg::CountW-1:0] loss_cnt_q, loss_cnt_d;
	logic [rclf_pkg::CountW-1:0] rec_cnt_q, rec_cnt_d;
	logic [rclf_pkg::FrameW-1:0] frame_cnt_q, frame_cnt_d;

	logic                        accept;
	logic [rclf_pkg::TimeW-1:0]  since_start, since_frame;
	rclf_pkg::out_item_t         result;

	assign cfg_ready = 1'b1;
	assign in_stall  = out_valid && out_stall;
	assign accept    = in_valid && !in_stall;

	// a frame that opens a new run starts it at its own time, so zero elapsed
	assign since_start = (phase_q == rclf_pkg::PH_RECOVERING) ?
	                     (in_data.now_ms - rec_start_q) : '0;
	assign since_frame = in_data.now_ms - last_frame_q;

	always_comb begin
		phase_d      = phase_q;
		seen_d       = seen_q;
		failsafe_d   = failsafe_q;
		last_frame_d = last_frame_q;
		rec_start_d  = rec_start_q;
		last_loss_d  = last_loss_q;
		loss_cnt_d   = loss_cnt_q;
		rec_cnt_d    = rec_cnt_q;
		frame_cnt_d  = frame_cnt_q;
		if (rclf_pkg::opcode_t'(in_data.opcode) == rclf_pkg::OP_FRAME) begin
			seen_d       = 1'b1;
			last_frame_d = in_data.now_ms;
			if (phase_q != rclf_pkg::PH_HEALTHY) begin
				if (phase_q != rclf_pkg::PH_RECOVERING) begin
					phase_d     = rclf_pkg::PH_RECOVERING;
					rec_start_d = in_data.now_ms;
					frame_cnt_d = {{(rclf_pkg::FrameW-1){1'b0}}, 1'b1};
				end else if (frame_cnt_q != rclf_pkg::FrameMax) begin
					frame_cnt_d = frame_cnt_q + 1'b1;
				end
				// healthy may be reached on the very frame that opens the run
				if (frame_cnt_d >= recovery_min_q &&
				    since_start >= {{(rclf_pkg::TimeW-rclf_pkg::CfgW){1'b0}},
				                    recovery_time_q}) begin
					phase_d    = rclf_pkg::PH_HEALTHY;
					failsafe_d = 1'b0;
					rec_cnt_d  = rec_cnt_q + 1'b1;
				end
			end
		end else if (seen_q && since_frame >= {{(rclf_pkg::TimeW-rclf_pkg::CfgW){1'b0}},
		                                       loss_timeout_q}) begin
			if (phase_q == rclf_pkg::PH_HEALTHY) begin
				loss_cnt_d  = loss_cnt_q + 1'b1;
				last_loss_d = in_data.now_ms;
			end
			phase_d     = rclf_pkg::PH_LOST;
			failsafe_d  = 1'b1;
			frame_cnt_d = '0;
		end
	end

	always_comb begin
		result.link_phase         = phase_d;
		result.failsafe_on        = failsafe_d;
		result.control_ok         = (phase_d == rclf_pkg::PH_HEALTHY) && !failsafe_d;
		result.failsafe_events    = loss_cnt_d;
		result.recovery_events    = rec_cnt_d;
		result.last_failsafe_time = last_loss_d;
		result.recovery_frames    = frame_cnt_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			loss_timeout_q  <= rclf_pkg::LossTimeoutRst;
			recovery_time_q <= rclf_pkg::RecoveryTimeRst;
			recovery_min_q  <= rclf_pkg::RecoveryMinRst;
		end else if (cfg_valid && cfg_ready) begin
			unique case (rclf_pkg::cfg_reg_t'(cfg_index))
				rclf_pkg::REG_LOSS_TIMEOUT:  loss_timeout_q  <= cfg_data;
				rclf_pkg::REG_RECOVERY_TIME: recovery_time_q <= cfg_data;
				rclf_pkg::REG_RECOVERY_MIN:  recovery_min_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q      <= rclf_pkg::PH_WAITING;
			seen_q       <= 1'b0;
			failsafe_q   <= 1'b1;
			last_frame_q <= '0;
			rec_start_q  <= '0;
			last_loss_q  <= '0;
			loss_cnt_q   <= '0;
			rec_cnt_q    <= '0;
			frame_cnt_q  <= '0;
		end else if (accept) begin
			phase_q      <= phase_d;
			seen_q       <= seen_d;
			failsafe_q   <= failsafe_d;
			last_frame_q <= last_frame_d;
			rec_start_q  <= rec_start_d;
			last_loss_q  <= last_loss_d;
			loss_cnt_q   <= loss_cnt_d;
			rec_cnt_q    <= rec_cnt_d;
			frame_cnt_q  <= frame_cnt_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (accept) begin
			out_valid <= 1'b1;
		end else if (!out_stall) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			out_data <= result;
		end
	end

	// failsafe is cleared only by entering healthy, and healthy is left only via lost
	a_failsafe_phase: assert property (@(posedge clk) disable iff (!arst_n)
		(failsafe_q == (phase_q != rclf_pkg::PH_HEALTHY)))
		else $error("failsafe flag disagrees with link phase");

	a_no_phase_before_frame: assert property (@(posedge clk) disable iff (!arst_n)
		!seen_q |-> (phase_q == rclf_pkg::PH_WAITING && frame_cnt_q == '0))
		else $error("link left waiting without a frame");

	a_accept_gives_result: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (out_valid && out_data.link_phase == phase_q &&
		            out_data.failsafe_events == loss_cnt_q))
		else $error("accepted request did not yield matching result");

	a_lost_clears_frames: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == rclf_pkg::PH_LOST) |-> (frame_cnt_q == '0))
		else $error("frame count nonzero while lost");

endmodule

`default_nettype wire
